@@ rtl/one_shot_match_timer_assert.svh @@
// assertion macros shared by the rtl
`ifndef ONE_SHOT_MATCH_TIMER_ASSERT_SVH
`define ONE_SHOT_MATCH_TIMER_ASSERT_SVH

`ifndef ASSERT_OFF

// checked on every clock edge outside reset
`define OMT_ASSERT(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// checked on every clock edge, reset included
`define OMT_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define OMT_ASSERT(lbl, clk_sig, rst_sig, prop, msg)
`define OMT_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)

`endif

`endif

@@ rtl/omt_pkg.sv @@
package omt_pkg;

  localparam int OPCODE_W = 3;
  localparam int PERIOD_W = 19;
  localparam int REMAIN_W = 19;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_CLEAR = 3'd3,
    OP_READ  = 3'd4
  } op_t;

  // 16 ticks per microsecond, 1000 microseconds per millisecond
  localparam int          TICK_US_SHIFT = 4;
  localparam int          TICKS_MS_W    = 14;
  localparam logic [13:0] TICKS_PER_MS  = 14'd16000;
  localparam int          LOAD_W        = PERIOD_W + TICKS_MS_W;

  // divide by 1000 as multiply by ceil(2^38/1000), exact for 28-bit operands
  localparam int          SCALED_W    = 28;
  localparam int          RECIP_W     = 29;
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          PROD_W      = SCALED_W + RECIP_W;

  // register map
  localparam int   APB_ADDR_W     = 3;
  localparam int   APB_DATA_W     = 32;
  localparam logic REG_IRQ_ENABLE = 1'b0;

endpackage

@@ rtl/omt_req_if.sv @@
interface omt_req_if import omt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [PERIOD_W-1:0] period_ms;

  modport source (output valid, output opcode, output period_ms, input ready);
  modport sink (input valid, input opcode, input period_ms, output ready);
endinterface

@@ rtl/omt_rsp_if.sv @@
interface omt_rsp_if import omt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [REMAIN_W-1:0] remaining_ms;
  logic                running;
  logic                timeout_raw;
  logic                timeout_irq;

  modport source (output valid, output remaining_ms, output running, output timeout_raw,
                  output timeout_irq, input ready);
  modport sink (input valid, input remaining_ms, input running, input timeout_raw,
                input timeout_irq, output ready);
endinterface

@@ rtl/one_shot_match_timer.sv @@
// channel   direction  handshake     payload
// req       in         valid/ready   opcode, period_ms
// rsp       out        valid/ready   remaining_ms, running, timeout_raw, timeout_irq
// apb       in         psel/penable  irq_enable at byte address 0
//
// one request per cycle while req.ready is high; the count is updated at acceptance,
// the divide by 16000 is one registered multiply, from which the response leaves;
// a stalled response holds the multiply stage, req.ready drops only when both are full
// rst clears the count, the flags and the pipeline, irq_enable comes up set
`include "one_shot_match_timer_assert.svh"

module one_shot_match_timer import omt_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  omt_req_if.sink               req,
  omt_rsp_if.source             rsp
);

  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic                   enable_flag;
  logic                   enable_flag_next;
  logic                   status_flag;
  logic                   status_flag_next;
  logic                   irq_enable;

  logic                   held;
  logic                   rsp_valid;
  logic [PROD_W-1:0]      product;
  logic                   rsp_running;
  logic                   rsp_raw;
  logic                   rsp_irq;

  logic                   req_acc;
  logic                   out_free;
  logic                   cfg_write;
  logic [LOAD_W-1:0]      load_full;
  logic [COUNT_WIDTH-1:0] count_dec;
  logic [SCALED_W-1:0]    scaled;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_IRQ_ENABLE);
  assign prdata    = (paddr[2] == REG_IRQ_ENABLE) ? APB_DATA_W'(irq_enable) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_enable <= 1'b1;
    end else if (cfg_write) begin
      irq_enable <= pwdata[0];
    end
  end

  // handshake: held marks state that has not yet gone into the multiply stage
  assign out_free  = !rsp_valid || rsp.ready;
  assign req.ready = !held || out_free;
  assign req_acc   = req.valid && req.ready;

  assign load_full = LOAD_W'(req.period_ms) * LOAD_W'(TICKS_PER_MS);
  assign count_dec = (tick_count != '0) ? tick_count - COUNT_WIDTH'(1) : tick_count;

  always_comb begin
    tick_count_next  = tick_count;
    enable_flag_next = enable_flag;
    status_flag_next = status_flag;
    case (op_t'(req.opcode))
      OP_TICK: begin
        if (enable_flag) begin
          tick_count_next = count_dec;
          if (count_dec == '0) begin
            status_flag_next = 1'b1;
            enable_flag_next = 1'b0;
          end
        end
      end
      OP_START: begin
        tick_count_next  = COUNT_WIDTH'(load_full);
        enable_flag_next = 1'b1;
      end
      OP_STOP: begin
        enable_flag_next = 1'b0;
      end
      OP_CLEAR: begin
        status_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      enable_flag <= 1'b0;
      status_flag <= 1'b0;
      held        <= 1'b0;
    end else begin
      if (req_acc) begin
        tick_count  <= tick_count_next;
        enable_flag <= enable_flag_next;
        status_flag <= status_flag_next;
        held        <= 1'b1;
      end else if (out_free) begin
        held        <= 1'b0;
      end
    end
  end

  // remaining_ms = floor(floor(count / 16) / 1000)
  assign scaled = SCALED_W'(tick_count >> TICK_US_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && held) begin
      product     <= PROD_W'(scaled) * PROD_W'(RECIP_1000);
      rsp_running <= enable_flag;
      rsp_raw     <= status_flag;
      rsp_irq     <= status_flag && irq_enable;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.remaining_ms = REMAIN_W'(product >> RECIP_SHIFT);
  assign rsp.running      = rsp_running;
  assign rsp.timeout_raw  = rsp_raw;
  assign rsp.timeout_irq  = rsp_irq;

  `OMT_ASSERT(a_start_runs, clk, rst,
    req_acc && (op_t'(req.opcode) == OP_START) |=> enable_flag,
    "start request did not enable the counter")
  `OMT_ASSERT(a_match_stops, clk, rst,
    req_acc && (op_t'(req.opcode) == OP_TICK) && enable_flag && (tick_count <= COUNT_WIDTH'(1))
      |=> status_flag && !enable_flag,
    "tick at match did not set status and stop")
  `OMT_ASSERT(a_status_source, clk, rst,
    $rose(status_flag) |-> $past(req_acc && (op_t'(req.opcode) == OP_TICK)),
    "timeout status set without a tick request")
  `OMT_ASSERT(a_full_blocks, clk, rst,
    held && rsp_valid && !rsp.ready |-> !req.ready,
    "request taken while both stages are full")
  `OMT_ASSERT_ALWAYS(a_reset_idle, clk,
    $past(rst) |-> !rsp_valid && !held,
    "pipeline not empty after reset")

endmodule
